// ===== rtl/core/vtlf_pkg.sv =====
`default_nettype none

package vtlf_pkg;

  localparam int DEF_NUMBER_DIGITS = 6;
  localparam int CFG_DATA_W        = 2;
  localparam int CFG_INDEX_W       = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_MODE      = 3'd0,
    REG_SHOW_ENDS        = 3'd1,
    REG_SHOW_TABS        = 3'd2,
    REG_SHOW_NONPRINTING = 3'd3,
    REG_SQUEEZE_EMPTY    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    NUM_OFF      = 2'd0,
    NUM_ALL      = 2'd1,
    NUM_NONBLANK = 2'd2
  } num_mode_t;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
    logic       squeeze_empty;
  } cfg_t;

  // Rendered body of one input byte: up to four bytes, first one in the top lane.
  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] bytes;
  } body_t;

  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_DASH     = 8'd45;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_QMARK    = 8'd63;
  localparam logic [7:0] CH_I        = 8'd73;
  localparam logic [7:0] CH_M        = 8'd77;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  function automatic int entry_width(input int digits);
    return 1 + 4 * digits + $bits(body_t);
  endfunction

  function automatic body_t render(input logic [7:0] c, input cfg_t cfg);
    logic [6:0]  low;
    logic [15:0] tail;
    logic [2:0]  tail_len;
    body_t       b;
    b        = '0;
    low      = c[6:0];
    tail     = '0;
    tail_len = 3'd1;
    if (c == CH_NL) begin
      if (cfg.show_ends) begin
        b.len   = 3'd2;
        b.bytes = {CH_DOLLAR, CH_NL, 16'h0000};
      end else begin
        b.len   = 3'd1;
        b.bytes = {CH_NL, 24'h000000};
      end
    end else if (c == CH_TAB) begin
      if (cfg.show_tabs) begin
        b.len   = 3'd2;
        b.bytes = {CH_CARET, CH_I, 16'h0000};
      end else begin
        b.len   = 3'd1;
        b.bytes = {CH_TAB, 24'h000000};
      end
    end else if (!cfg.show_nonprinting || (c >= CH_SPACE && c < CH_DEL)) begin
      b.len   = 3'd1;
      b.bytes = {c, 24'h000000};
    end else begin
      if ({1'b0, low} < CH_SPACE) begin
        tail     = {CH_CARET, {1'b0, low} + CTRL_OFFSET};
        tail_len = 3'd2;
      end else if ({1'b0, low} == CH_DEL) begin
        tail     = {CH_CARET, CH_QMARK};
        tail_len = 3'd2;
      end else begin
        tail     = {{1'b0, low}, 8'h00};
        tail_len = 3'd1;
      end
      if (c[7]) begin
        b.len   = tail_len + 3'd2;
        b.bytes = {CH_M, CH_DASH, tail};
      end else begin
        b.len   = tail_len;
        b.bytes = {tail, 16'h0000};
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vtlf_in_if.sv =====
`default_nettype none

interface vtlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vtlf_out_if.sv =====
`default_nettype none

interface vtlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vtlf_front.sv =====
`default_nettype none

module vtlf_front
  import vtlf_pkg::*;
#(
  parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire cfg_t                                    cfg,
  vtlf_in_if.sink                                      in_ch,
  output logic                                         q_push,
  output logic [entry_width(NUMBER_DIGITS)-1:0]        q_data,
  input  wire logic                                    q_full
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;

  logic             after_newline_r;
  logic             squeezing_r;
  logic [BCD_W-1:0] bcd_r;

  logic             accept;
  logic             an;
  logic             sq;
  logic [BCD_W-1:0] cnt;
  logic [BCD_W-1:0] cnt_inc;
  logic [BCD_W-1:0] cnt_nxt;
  logic             nl;
  logic             drop;
  logic             number;
  body_t            body;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A new file restarts the line state before the byte is looked at.
  assign an  = in_ch.file_start ? 1'b1 : after_newline_r;
  assign sq  = in_ch.file_start ? 1'b0 : squeezing_r;
  assign cnt = in_ch.file_start ? '0 : bcd_r;

  assign nl     = (in_ch.in_byte == CH_NL);
  assign drop   = nl && sq && cfg.squeeze_empty;
  assign number = an && ((cfg.number_mode == NUM_ALL) ||
                         ((cfg.number_mode == NUM_NONBLANK) && !nl));

  // Decimal increment; a counter of all nines comes out with the carry still set
  // and is then kept as it was.
  always_comb begin
    logic       carry;
    logic [3:0] d;
    carry   = 1'b1;
    cnt_inc = cnt;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = cnt[4*i +: 4];
      if (carry) begin
        if (d == 4'd9) begin
          cnt_inc[4*i +: 4] = 4'd0;
        end else begin
          cnt_inc[4*i +: 4] = d + 4'd1;
          carry             = 1'b0;
        end
      end
    end
    if (carry) begin
      cnt_inc = cnt;
    end
  end

  assign cnt_nxt = number ? cnt_inc : cnt;
  assign body    = render(in_ch.in_byte, cfg);

  assign q_push = accept && !drop;
  assign q_data = {number, cnt_nxt, body};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_newline_r <= 1'b1;
      squeezing_r     <= 1'b0;
      bcd_r           <= '0;
    end else if (q_push) begin
      after_newline_r <= nl;
      squeezing_r     <= nl && an && cfg.squeeze_empty;
      bcd_r           <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vtlf_queue.sv =====
`default_nettype none

module vtlf_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              valid
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("queue pushed while full");

endmodule

`default_nettype wire

// ===== rtl/core/vtlf_back.sv =====
`default_nettype none

module vtlf_back
  import vtlf_pkg::*;
#(
  parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_valid,
  input  wire logic [entry_width(NUMBER_DIGITS)-1:0] q_data,
  output logic                                      q_pop,
  vtlf_out_if.source                                out_ch
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int NL_W  = $clog2(NUMBER_DIGITS + 2);

  logic             active_r;
  logic [NL_W-1:0]  num_left_r;
  logic [BCD_W-1:0] bcd_r;
  logic             seen_r;
  logic [31:0]      body_r;
  logic [2:0]       body_left_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             head_number;
  logic [BCD_W-1:0] head_bcd;
  body_t            head_body;
  logic             advance;
  logic             done_now;
  logic [3:0]       top;
  logic             in_digits;
  logic             space;
  logic [7:0]       emit_byte;
  logic             emit_last;

  assign {head_number, head_bcd, head_body} = q_data;

  assign advance   = active_r && (!out_valid_r || out_ch.ready);
  assign done_now  = advance && (num_left_r == '0) && (body_left_r == 3'd1);
  assign q_pop     = q_valid && (!active_r || done_now);

  assign top       = bcd_r[BCD_W-1 -: 4];
  assign in_digits = (num_left_r > NL_W'(1));
  // Leading zeros print as spaces, but the units digit always prints.
  assign space     = (top == 4'd0) && !seen_r && (num_left_r != NL_W'(2));

  always_comb begin
    if (in_digits) begin
      emit_byte = space ? CH_SPACE : (CH_ZERO | {4'd0, top});
      emit_last = 1'b0;
    end else if (num_left_r == NL_W'(1)) begin
      emit_byte = CH_TAB;
      emit_last = 1'b0;
    end else begin
      emit_byte = body_r[31:24];
      emit_last = (body_left_r == 3'd1);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      num_left_r  <= '0;
      body_left_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= emit_byte;
        out_last_r  <= emit_last;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (q_pop) begin
        active_r    <= 1'b1;
        num_left_r  <= head_number ? NL_W'(NUMBER_DIGITS + 1) : '0;
        bcd_r       <= head_bcd;
        seen_r      <= 1'b0;
        body_r      <= head_body.bytes;
        body_left_r <= head_body.len;
      end else if (advance) begin
        if (in_digits) begin
          bcd_r      <= bcd_r << 4;
          seen_r     <= seen_r || (top != 4'd0);
          num_left_r <= num_left_r - NL_W'(1);
        end else if (num_left_r == NL_W'(1)) begin
          num_left_r <= '0;
        end else begin
          body_r      <= body_r << 8;
          body_left_r <= body_left_r - 3'd1;
        end
        if (done_now) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (num_left_r != '0) || (body_left_r != 3'd0))
    else $error("back end active with nothing left to emit");

  a_num_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    num_left_r <= NL_W'(NUMBER_DIGITS + 1))
    else $error("number byte count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/visible_text_line_filter.sv =====
`default_nettype none

// Channel   Direction  Payload                     Transaction when
// in_ch     sink       in_byte[7:0], file_start    valid && ready
// out_ch    source     out_byte[7:0], last_of_run  valid && ready
// cfg_*     write      cfg_index[2:0], cfg_wdata   cfg_we high
//
// Output runs at one byte per cycle while out_ch is ready; an input byte yields
// 1 to NUMBER_DIGITS + 5 bytes, so bursts of plain text run at one input per cycle
// and numbered lines or escapes take longer.
// The front end takes an input every cycle while the two-entry queue has room;
// a dropped blank line is taken from in_ch and yields nothing.
// The first byte of an item goes through the queue and the back-end registers to out_ch.
// Reset is synchronous on rst_n and clears the control registers, configuration and line state.

module visible_text_line_filter
  import vtlf_pkg::*;
#(
  parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  vtlf_in_if.sink                     in_ch,
  vtlf_out_if.source                  out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ENTRY_W = entry_width(NUMBER_DIGITS);

  cfg_t               cfg_r;
  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUMBER_MODE:      cfg_r.number_mode      <= cfg_wdata;
        REG_SHOW_ENDS:        cfg_r.show_ends        <= cfg_wdata[0];
        REG_SHOW_TABS:        cfg_r.show_tabs        <= cfg_wdata[0];
        REG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= cfg_wdata[0];
        REG_SQUEEZE_EMPTY:    cfg_r.squeeze_empty    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  vtlf_front #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  vtlf_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .valid     (q_valid)
  );

  vtlf_back #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
